### rtl/core/assert_macros.svh
// Assertion macros shared by the translation table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ARTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ARTT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/artt_pkg.sv
// Package with the request kinds, status codes and control types of the translation table.
`timescale 1ns / 1ps

package artt_pkg;

    localparam int ADDR_W   = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_MISS      = 3'd4
    } t_status;

    // Update commands from the sequencer to the entry table.
    typedef struct packed {
        logic wr_en;    // write an entry and mark it valid
        logic clr_one;  // drop the valid bit of one entry
        logic clr_all;  // drop every valid bit
    } t_tbl_ctl;

endpackage

### rtl/core/artt_table.sv
// Entry storage: region memories with a registered read port and per-entry valid bits.
`timescale 1ns / 1ps

module artt_table #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  artt_pkg::t_tbl_ctl          i_ctl,
    input  logic [IDX_W-1:0]            i_waddr,
    input  logic [artt_pkg::ADDR_W-1:0] i_wr_base,
    input  logic [artt_pkg::ADDR_W-1:0] i_wr_host,
    input  logic [artt_pkg::ADDR_W-1:0] i_wr_len,
    input  logic [IDX_W-1:0]            i_raddr,
    output logic                        o_rd_valid,
    output logic [artt_pkg::ADDR_W-1:0] o_rd_base,
    output logic [artt_pkg::ADDR_W-1:0] o_rd_host,
    output logic [artt_pkg::ADDR_W-1:0] o_rd_len
);

    logic [artt_pkg::ADDR_W-1:0] r_mem_base [ENTRIES];
    logic [artt_pkg::ADDR_W-1:0] r_mem_host [ENTRIES];
    logic [artt_pkg::ADDR_W-1:0] r_mem_len  [ENTRIES];
    logic [ENTRIES-1:0]          r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_base[i_waddr] <= i_wr_base;
            r_mem_host[i_waddr] <= i_wr_host;
            r_mem_len[i_waddr]  <= i_wr_len;
        end
        o_rd_base <= r_mem_base[i_raddr];
        o_rd_host <= r_mem_host[i_raddr];
        o_rd_len  <= r_mem_len[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= r_valid[i_raddr];
            if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_waddr] <= 1'b1;
            end else if (i_ctl.clr_one) begin
                r_valid[i_waddr] <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/artt_alu.sv
// Shared 64-bit add/subtract unit with carry and zero flags.
`timescale 1ns / 1ps

module artt_alu (
    input  logic [artt_pkg::ADDR_W-1:0] i_a,
    input  logic [artt_pkg::ADDR_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [artt_pkg::ADDR_W-1:0] o_sum,
    output logic                        o_carry,
    output logic                        o_zero
);

    logic [artt_pkg::ADDR_W-1:0] w_b;

    // For a subtract, carry out set means a >= b.
    assign w_b = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, w_b}
                            + {{artt_pkg::ADDR_W{1'b0}}, i_sub};
    assign o_zero = (o_sum == '0);

endmodule

### rtl/core/artt_ctrl.sv
// Sequencer that scans the entries through the shared unit and forms each result.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module artt_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  artt_pkg::t_func             i_func,
    input  logic [artt_pkg::ADDR_W-1:0] i_guest_addr,
    input  logic [artt_pkg::ADDR_W-1:0] i_host_base,
    input  logic [artt_pkg::ADDR_W-1:0] i_region_size,
    output artt_pkg::t_tbl_ctl          o_tbl_ctl,
    output logic [IDX_W-1:0]            o_waddr,
    output logic [artt_pkg::ADDR_W-1:0] o_wr_base,
    output logic [artt_pkg::ADDR_W-1:0] o_wr_host,
    output logic [artt_pkg::ADDR_W-1:0] o_wr_len,
    output logic [IDX_W-1:0]            o_raddr,
    input  logic                        i_rd_valid,
    input  logic [artt_pkg::ADDR_W-1:0] i_rd_base,
    input  logic [artt_pkg::ADDR_W-1:0] i_rd_host,
    input  logic [artt_pkg::ADDR_W-1:0] i_rd_len,
    output logic [artt_pkg::ADDR_W-1:0] o_alu_a,
    output logic [artt_pkg::ADDR_W-1:0] o_alu_b,
    output logic                        o_alu_sub,
    input  logic [artt_pkg::ADDR_W-1:0] i_alu_sum,
    input  logic                        i_alu_carry,
    input  logic                        i_alu_zero,
    input  logic                        i_out_full,
    output logic                        o_push,
    output artt_pkg::t_status           o_status,
    output logic [artt_pkg::ADDR_W-1:0] o_host_addr
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CMPA = 8'b0000_0010,
        S_CMPB = 8'b0000_0100,
        S_DEC  = 8'b0000_1000,
        S_L1   = 8'b0001_0000,
        S_L2   = 8'b0010_0000,
        S_L3   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [IDX_W-1:0]            r_idx;
    artt_pkg::t_func             r_func;
    logic [artt_pkg::ADDR_W-1:0] r_addr, r_host, r_size;
    logic [artt_pkg::ADDR_W-1:0] r_diff, r_tmp;
    logic                        r_cand, r_eq;
    logic                        r_found, r_free_found, r_have_best, r_best_exact;
    logic [IDX_W-1:0]            r_match_idx, r_free_idx;
    logic [artt_pkg::ADDR_W-1:0] r_best_diff, r_best_base, r_best_host, r_best_len;
    artt_pkg::t_status           r_status;
    logic [artt_pkg::ADDR_W-1:0] r_res_host;
    logic                        w_accept, w_last, w_take;

    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_last      = (r_idx == IDX_W'(ENTRIES - 1));
    // A lookup candidate replaces the best one when its base is closer below the address.
    assign w_take      = (r_func == artt_pkg::FN_LOOKUP) && r_cand
                      && (!r_have_best || !i_alu_carry);

    // The read address runs one entry ahead during the second step of each entry but the last.
    always_comb begin
        o_raddr = r_idx;
        if (r_state == S_IDLE) begin
            o_raddr = '0;
        end else if (r_state == S_CMPB && !w_last) begin
            o_raddr = r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        o_alu_a   = r_addr;
        o_alu_b   = i_rd_base;
        o_alu_sub = 1'b1;
        unique case (r_state)
            S_CMPB: begin
                o_alu_a = r_diff;
                o_alu_b = r_best_diff;
            end
            S_L1: begin
                o_alu_a   = r_best_base;
                o_alu_b   = r_best_len;
                o_alu_sub = 1'b0;
            end
            S_L2: begin
                o_alu_b = r_tmp;
            end
            S_L3: begin
                o_alu_a   = r_best_host;
                o_alu_b   = r_best_diff;
                o_alu_sub = 1'b0;
            end
            default: begin
                o_alu_a = r_addr;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_func == artt_pkg::FN_CLEAR) ? S_DEC : S_CMPA;
                end
            end
            S_CMPA: n_state = S_CMPB;
            S_CMPB: n_state = w_last ? S_DEC : S_CMPA;
            S_DEC: begin
                if (r_func == artt_pkg::FN_LOOKUP && r_have_best) begin
                    n_state = r_best_exact ? S_L3 : S_L1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_L1: n_state = S_L2;
            S_L2: n_state = i_alu_carry ? S_DONE : S_L3;
            S_L3: n_state = S_DONE;
            S_DONE: begin
                if (!i_out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_tbl_ctl = '0;
        o_waddr   = r_match_idx;
        if (r_state == S_DEC) begin
            unique case (r_func)
                artt_pkg::FN_ADD: begin
                    o_waddr         = r_free_idx;
                    o_tbl_ctl.wr_en = !r_found && r_free_found;
                end
                artt_pkg::FN_REMOVE: o_tbl_ctl.clr_one = r_found;
                artt_pkg::FN_CLEAR:  o_tbl_ctl.clr_all = 1'b1;
                default:             o_tbl_ctl = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMPB) begin
                r_idx <= w_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_func       <= i_func;
                    r_addr       <= i_guest_addr;
                    r_host       <= i_host_base;
                    r_size       <= i_region_size;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    r_have_best  <= 1'b0;
                    r_res_host   <= '0;
                end
            end
            S_CMPA: begin
                r_diff <= i_alu_sum;
                r_cand <= i_rd_valid && i_alu_carry;
                r_eq   <= i_alu_zero;
                if (i_rd_valid && i_alu_zero && !r_found) begin
                    r_found     <= 1'b1;
                    r_match_idx <= r_idx;
                end
                if (!i_rd_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
            end
            S_CMPB: begin
                if (w_take) begin
                    r_have_best  <= 1'b1;
                    r_best_exact <= r_eq;
                    r_best_diff  <= r_diff;
                    r_best_base  <= i_rd_base;
                    r_best_host  <= i_rd_host;
                    r_best_len   <= i_rd_len;
                end
            end
            S_DEC: begin
                unique case (r_func)
                    artt_pkg::FN_ADD: begin
                        if (r_found) begin
                            r_status <= artt_pkg::ST_DUP;
                        end else if (r_free_found) begin
                            r_status <= artt_pkg::ST_OK;
                        end else begin
                            r_status <= artt_pkg::ST_FULL;
                        end
                    end
                    artt_pkg::FN_REMOVE: begin
                        r_status <= r_found ? artt_pkg::ST_OK : artt_pkg::ST_NOT_FOUND;
                    end
                    artt_pkg::FN_LOOKUP: r_status <= artt_pkg::ST_MISS;
                    default:             r_status <= artt_pkg::ST_OK;
                endcase
            end
            S_L1: r_tmp <= i_alu_sum;
            S_L3: begin
                r_status   <= artt_pkg::ST_OK;
                r_res_host <= i_alu_sum;
            end
            default: begin
                r_tmp <= r_tmp;
            end
        endcase
    end

    assign o_wr_base   = r_addr;
    assign o_wr_host   = r_host;
    assign o_wr_len    = r_size;
    assign o_push      = (r_state == S_DONE) && !i_out_full;
    assign o_status    = r_status;
    assign o_host_addr = r_res_host;

    `ARTT_ASSERT(a_accept_starts, (r_state == S_IDLE && i_req_valid) |=> (r_state == S_CMPA || r_state == S_DEC), "accepted request did not start")
    `ARTT_ASSERT(a_idx_range, int'(r_idx) < ENTRIES, "scan index beyond the table")
    `ARTT_NEVER(a_no_dup_write, o_tbl_ctl.wr_en && r_found, "entry written over a duplicate base")
    `ARTT_ASSERT(a_scan_order, (r_state == S_CMPB) |-> ($past(r_state) == S_CMPA), "second scan step out of order")

endmodule

### rtl/core/address_range_translation_table_top.sv
// Top level of the guest-to-host address range translation table.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: func; tdata: guest_addr, host_base,
//                                             region_size
// m_axis   out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: host_addr
//
// An add, remove or lookup scans every entry through one shared 64-bit adder, in the
// compare steps S_CMPA and S_CMPB for each entry; a clear skips the scan.
// The synchronous active-low reset clears all valid bits and the control state at once.
// The result register lets the next request be accepted while a result waits; a held
// result stalls the sequencer only when the following result is ready.

module address_range_translation_table_top #(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // guest_addr [63:0], host_base [127:64],
                                        // region_size [191:128]
    input  logic [1:0]   s_axis_tuser,  // func [1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // host_addr [63:0]
    output logic [2:0]   m_axis_tuser   // status [2:0]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    artt_pkg::t_tbl_ctl          w_tbl_ctl;
    logic [IDX_W-1:0]            w_waddr, w_raddr;
    logic [artt_pkg::ADDR_W-1:0] w_wr_base, w_wr_host, w_wr_len;
    logic                        w_rd_valid;
    logic [artt_pkg::ADDR_W-1:0] w_rd_base, w_rd_host, w_rd_len;
    logic [artt_pkg::ADDR_W-1:0] w_alu_a, w_alu_b, w_alu_sum;
    logic                        w_alu_sub, w_alu_carry, w_alu_zero;
    logic                        w_out_full, w_push;
    artt_pkg::t_status           w_status;
    logic [artt_pkg::ADDR_W-1:0] w_host_addr;
    logic                        r_out_valid;
    logic [artt_pkg::STATUS_W-1:0] r_out_status;
    logic [artt_pkg::ADDR_W-1:0] r_out_host;

    artt_ctrl #(
        .ENTRIES(ENTRIES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_func       (artt_pkg::t_func'(s_axis_tuser)),
        .i_guest_addr (s_axis_tdata[63:0]),
        .i_host_base  (s_axis_tdata[127:64]),
        .i_region_size(s_axis_tdata[191:128]),
        .o_tbl_ctl    (w_tbl_ctl),
        .o_waddr      (w_waddr),
        .o_wr_base    (w_wr_base),
        .o_wr_host    (w_wr_host),
        .o_wr_len     (w_wr_len),
        .o_raddr      (w_raddr),
        .i_rd_valid   (w_rd_valid),
        .i_rd_base    (w_rd_base),
        .i_rd_host    (w_rd_host),
        .i_rd_len     (w_rd_len),
        .o_alu_a      (w_alu_a),
        .o_alu_b      (w_alu_b),
        .o_alu_sub    (w_alu_sub),
        .i_alu_sum    (w_alu_sum),
        .i_alu_carry  (w_alu_carry),
        .i_alu_zero   (w_alu_zero),
        .i_out_full   (w_out_full),
        .o_push       (w_push),
        .o_status     (w_status),
        .o_host_addr  (w_host_addr)
    );

    artt_table #(
        .ENTRIES(ENTRIES),
        .IDX_W  (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tbl_ctl),
        .i_waddr   (w_waddr),
        .i_wr_base (w_wr_base),
        .i_wr_host (w_wr_host),
        .i_wr_len  (w_wr_len),
        .i_raddr   (w_raddr),
        .o_rd_valid(w_rd_valid),
        .o_rd_base (w_rd_base),
        .o_rd_host (w_rd_host),
        .o_rd_len  (w_rd_len)
    );

    artt_alu u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .i_sub  (w_alu_sub),
        .o_sum  (w_alu_sum),
        .o_carry(w_alu_carry),
        .o_zero (w_alu_zero)
    );

    // The result register is free when empty or when its result leaves this cycle.
    assign w_out_full = r_out_valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_status <= w_status;
            r_out_host   <= w_host_addr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_host;
    assign m_axis_tuser  = r_out_status;

    `ARTT_ASSERT(a_miss_zero, (m_axis_tvalid && m_axis_tuser != artt_pkg::ST_OK) |-> (m_axis_tdata == '0), "non-hit result carries an address")
    `ARTT_NEVER(a_no_overwrite, r_out_valid && !m_axis_tready && w_push, "held result overwritten")
    `ARTT_NEVER(a_busy_not_ready, s_axis_tready && w_push, "result pushed while idle")

endmodule
